// ===== rtl/core/obbt_pkg.sv =====
// Shared types and constants for the best bid / best offer tracker.
// No dependencies.
package obbt_pkg;
    localparam logic [2:0] ST_REMOVED = 3'd0;
    localparam logic [2:0] ST_UPDATED = 3'd1;
    localparam logic [2:0] ST_ADDED   = 3'd2;
    localparam logic [2:0] ST_IGNORED = 3'd3;
    localparam logic [2:0] ST_DROPPED = 3'd4;
    localparam logic [31:0] PRICE_NONE_ASK = 32'hFFFF_FFFF;
    localparam logic [31:0] PRICE_NONE_BID = 32'h0000_0000;

    typedef struct packed {
        logic        side;
        logic [31:0] firm_id;
        logic [31:0] price;
        logic [31:0] size;
    } t_quote;
endpackage

// ===== rtl/core/obbt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module obbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/core/obbt_front.sv =====
// Front end: accepts quotes into a two-entry queue for the back end.
// Depends on obbt_pkg.
module obbt_front
    import obbt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_stall,
    input  t_quote i_quote,
    output logic   o_valid,
    input  logic   i_take,
    output t_quote o_quote
);
    t_quote     r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    logic       push;
    logic       pop;

    assign o_stall = (r_cnt == 2'd2);
    assign push    = i_valid && !o_stall;
    assign pop     = i_take && (r_cnt != 2'd0);
    assign o_valid = (r_cnt != 2'd0);
    assign o_quote = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= i_quote;
        end
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== rtl/core/obbt_back.sv =====
// Back end: walks one side of the quote table in memory, applies the quote,
// rescans on removal at the best price and holds the result. Uses obbt_ram.
module obbt_back
    import obbt_pkg::*;
#(
    parameter int SIDE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_take,
    input  t_quote      i_quote,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic        o_bbo_changed,
    output logic [31:0] o_best_bid_price,
    output logic [31:0] o_best_bid_size,
    output logic [31:0] o_best_ask_price,
    output logic [31:0] o_best_ask_size
);
    localparam int IW = $clog2(SIDE_DEPTH);
    localparam int AW = IW + 1;
    localparam int CW = $clog2(SIDE_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(SIDE_DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MATCH = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]    r_state;
    t_quote        r_q;
    logic [CW-1:0] r_cnt_bid;
    logic [CW-1:0] r_cnt_ask;
    logic [CW-1:0] cnt;
    logic [CW-1:0] r_idx;
    logic          r_rvld;
    logic [IW-1:0] r_ridx;
    logic          r_hit;
    logic [IW-1:0] r_match;
    logic [31:0]   r_mprice;
    logic          r_found;
    logic [31:0]   r_bp;
    logic [31:0]   r_bs;
    logic [31:0]   r_bbp, r_bbs, r_bap, r_bas;
    logic [31:0]   r_obbp, r_obbs, r_obap, r_obas;
    logic [2:0]    r_status;
    logic          r_ovalid;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [95:0]   wdata, rdata;
    logic [31:0]   rfirm, rprice, rsize;
    logic [31:0]   limit;
    logic          better;

    // Each side owns a power-of-two half so that the side bit can head the address.
    obbt_ram #(.WIDTH(96), .DEPTH(2 ** AW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign {rfirm, rprice, rsize} = rdata;
    assign cnt    = r_q.side ? r_cnt_ask : r_cnt_bid;
    assign limit  = r_q.side ? r_bap : r_bbp;
    assign better = r_q.side ? (rprice >= limit && rprice < r_bp)
                             : (rprice <= limit && rprice > r_bp);
    assign raddr  = {r_q.side, r_idx[IW-1:0]};
    assign o_take = (r_state == S_IDLE) && !r_ovalid;

    always_comb begin
        we    = 1'b0;
        waddr = {r_q.side, r_idx[IW-1:0]};
        wdata = rdata;
        if (r_state == S_DEC && !r_hit && r_q.size != 32'd0 && cnt != FULL) begin
            we    = 1'b1;
            waddr = {r_q.side, cnt[IW-1:0]};
            wdata = {r_q.firm_id, r_q.price, r_q.size};
        end else if (r_state == S_DEC && r_hit && r_q.size != 32'd0) begin
            we    = 1'b1;
            waddr = {r_q.side, r_match};
            wdata = {r_q.firm_id, r_q.price, r_q.size};
        end else if (r_state == S_SHIFT && r_rvld) begin
            // Entry read last cycle moves down one slot.
            we    = 1'b1;
            waddr = {r_q.side, r_ridx - IW'(1)};
        end
    end

    assign o_valid          = r_ovalid;
    assign o_status         = r_status;
    assign o_best_bid_price = r_bbp;
    assign o_best_bid_size  = r_bbs;
    assign o_best_ask_price = r_bap;
    assign o_best_ask_size  = r_bas;
    assign o_bbo_changed    = (r_obbp != r_bbp) || (r_obbs != r_bbs)
                           || (r_obap != r_bap) || (r_obas != r_bas);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_rvld    <= 1'b0;
            r_cnt_bid <= '0;
            r_cnt_ask <= '0;
            r_bbp     <= PRICE_NONE_BID;
            r_bbs     <= 32'd0;
            r_bap     <= PRICE_NONE_ASK;
            r_bas     <= 32'd0;
        end else begin
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            r_rvld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_take) begin
                        r_q    <= i_quote;
                        r_idx  <= '0;
                        r_hit  <= 1'b0;
                        r_obbp <= r_bbp;
                        r_obbs <= r_bbs;
                        r_obap <= r_bap;
                        r_obas <= r_bas;
                        r_state <= S_MATCH;
                    end
                end
                S_MATCH: begin
                    // Read address issued this cycle, data compared next.
                    if (r_rvld && !r_hit && rfirm == r_q.firm_id
                            && rprice == r_q.price) begin
                        r_hit    <= 1'b1;
                        r_match  <= r_ridx;
                        r_mprice <= rprice;
                    end
                    if (r_idx < cnt) begin
                        r_rvld <= 1'b1;
                        r_ridx <= r_idx[IW-1:0];
                        r_idx  <= r_idx + CW'(1);
                    end else if (!r_rvld) begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_idx   <= '0;
                    r_found <= 1'b0;
                    r_bp    <= r_q.side ? PRICE_NONE_ASK : PRICE_NONE_BID;
                    r_bs    <= 32'd0;
                    r_state <= S_OUT;
                    if (r_hit && r_q.size == 32'd0) begin
                        r_status <= ST_REMOVED;
                        r_state  <= (r_mprice == limit) ? S_SCAN : S_SHIFT;
                        r_idx    <= (r_mprice == limit) ? '0
                                                        : CW'(r_match) + CW'(1);
                    end else if (r_hit) begin
                        r_status <= ST_UPDATED;
                    end else if (r_q.size == 32'd0) begin
                        r_status <= ST_IGNORED;
                    end else if (cnt == FULL) begin
                        r_status <= ST_DROPPED;
                    end else begin
                        r_status <= ST_ADDED;
                        if (r_q.side) begin
                            r_cnt_ask <= r_cnt_ask + CW'(1);
                            if (r_bap > r_q.price) begin
                                r_bap <= r_q.price;
                                r_bas <= r_q.size;
                            end
                        end else begin
                            r_cnt_bid <= r_cnt_bid + CW'(1);
                            if (r_bbp < r_q.price) begin
                                r_bbp <= r_q.price;
                                r_bbs <= r_q.size;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    if (r_rvld && r_ridx != r_match && better) begin
                        r_bp    <= rprice;
                        r_bs    <= rsize;
                        r_found <= 1'b1;
                    end
                    if (r_idx < cnt) begin
                        r_rvld <= 1'b1;
                        r_ridx <= r_idx[IW-1:0];
                        r_idx  <= r_idx + CW'(1);
                    end else if (!r_rvld) begin
                        if (r_q.side) begin
                            r_bap <= r_bp;
                            r_bas <= r_found ? r_bs : 32'd0;
                        end else begin
                            r_bbp <= r_bp;
                            r_bbs <= r_found ? r_bs : 32'd0;
                        end
                        r_idx   <= CW'(r_match) + CW'(1);
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (r_idx < cnt) begin
                        r_rvld <= 1'b1;
                        r_ridx <= r_idx[IW-1:0];
                        r_idx  <= r_idx + CW'(1);
                    end else if (!r_rvld) begin
                        if (r_q.side) begin
                            r_cnt_ask <= r_cnt_ask - CW'(1);
                        end else begin
                            r_cnt_bid <= r_cnt_bid - CW'(1);
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/core/order_book_bbo_tracker_top.sv =====
// Best bid / best offer tracker. A quote waits in the front queue, and the back
// end matches it against the entries held on its side (one memory read per
// cycle) before its response is valid. A removal adds a shift pass, and a
// removal at the best price also a rescan of that side. The back end takes the
// next quote only once it is idle and the last response has been taken, so not
// while a response is stalled.
// Synchronous active-low reset empties both sides and sets the empty levels.
module order_book_bbo_tracker_top
    import obbt_pkg::*;
#(
    parameter int SIDE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_side,
    input  logic [31:0] i_firm_id,
    input  logic [31:0] i_price,
    input  logic [31:0] i_size,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic        o_bbo_changed,
    output logic [31:0] o_best_bid_price,
    output logic [31:0] o_best_bid_size,
    output logic [31:0] o_best_ask_price,
    output logic [31:0] o_best_ask_size
);
    t_quote in_q, q;
    logic   q_valid, q_take;

    assign in_q = '{side: i_side, firm_id: i_firm_id, price: i_price, size: i_size};

    obbt_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_quote(in_q),
        .o_valid(q_valid),
        .i_take (q_take),
        .o_quote(q)
    );

    obbt_back #(.SIDE_DEPTH(SIDE_DEPTH)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .o_take          (q_take),
        .i_quote         (q),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_bbo_changed   (o_bbo_changed),
        .o_best_bid_price(o_best_bid_price),
        .o_best_bid_size (o_best_bid_size),
        .o_best_ask_price(o_best_ask_price),
        .o_best_ask_size (o_best_ask_size)
    );
endmodule
